FILE: src/owm_pkg.sv
// Shared types and constants for the 1-Wire bus master.
`timescale 1ns / 1ps

package owm_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 20;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_RESET_LOW = 3'd0,
    CFG_PRES_WAIT = 3'd1,
    CFG_RECOVERY  = 3'd2,
    CFG_SLOT      = 3'd3,
    CFG_SAMPLE    = 3'd4,
    CFG_PULLUP    = 3'd5
  } owm_cfg_idx_e;

  // Command codes carried in the opcode field.
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_RESET  = 3'd1,
    OP_WRITE  = 3'd2,
    OP_READ   = 3'd3,
    OP_PULLUP = 3'd4
  } owm_op_e;

  // Bus sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_POLL = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_HIGH  = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_REST  = 4'd8,
    PH_PULLUP   = 4'd9
  } owm_phase_e;

  // Reset values of the configuration registers.
  localparam logic [11:0] ResetLowDefault  = 12'd500;
  localparam logic [11:0] PresWaitDefault  = 12'd250;
  localparam logic [11:0] RecoveryDefault  = 12'd500;
  localparam logic [7:0]  SlotDefault      = 8'd60;
  localparam logic [7:0]  SampleDefault    = 8'd4;
  localparam logic [19:0] PullupDefault    = 20'd750000;

  // One result word.
  typedef struct packed {
    logic       drive_low;
    logic       pullup_on;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_value;
    logic       rejected;
  } owm_res_t;

endpackage

FILE: src/owm_if.sv
// Valid/ready channel interfaces for command ticks and results.
`timescale 1ns / 1ps

interface owm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] data_byte;
  logic       line_sample;

  modport source (output valid, opcode, data_byte, line_sample, input ready);
  modport sink   (input valid, opcode, data_byte, line_sample, output ready);
endinterface

interface owm_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       pullup_on;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_value;
  logic       rejected;

  modport source (output valid, drive_low, pullup_on, busy_res, done_res, presence,
                  read_value, rejected, input ready);
  modport sink   (input valid, drive_low, pullup_on, busy_res, done_res, presence,
                  read_value, rejected, output ready);
endinterface

FILE: src/onewire_master_controller.sv
// 1-Wire bus master: tick-driven reset/presence, byte write/read and strong pull-up.
// Each accepted tick word loads its result word into the output register.
// Throughput: one tick word per cycle unless the result stalls; the whole phase step
// is one pass of logic between the sequencer state registers and the output register.
// Reset: rst_ni is asynchronous and active low; it idles the sequencer, clears
// presence and the read byte, and loads the default timing registers.
`timescale 1ns / 1ps

module onewire_master_controller #(
  parameter int unsigned TIMER_WIDTH = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [owm_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [owm_pkg::CfgDataWidth-1:0]  cfg_data_i,
  owm_cmd_if.sink                           cmd_i,
  owm_res_if.source                         res_o
);

  // Width used to compare a loaded length against the timer's maximum.
  localparam int unsigned LoadWidth = (TIMER_WIDTH > 20) ? TIMER_WIDTH : 20;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  // Load a length into the tick timer: optionally bump zero to one, then
  // saturate at the timer's maximum.
  function automatic timer_t timer_load(input logic [19:0] v, input logic at_least_one);
    logic [19:0]          w;
    logic [LoadWidth-1:0] ext;
    w   = (at_least_one && (v == 20'd0)) ? 20'd1 : v;
    ext = LoadWidth'(w);
    if (ext > LoadWidth'(TimerMax)) begin
      return TimerMax;
    end
    return TIMER_WIDTH'(ext);
  endfunction

  // ---------------------------------------------------------------------------
  // Timing registers
  // ---------------------------------------------------------------------------
  logic [11:0] reset_low_q, pres_wait_q, recovery_q;
  logic [7:0]  slot_q, sample_q;
  logic [19:0] pullup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q <= owm_pkg::ResetLowDefault;
      pres_wait_q <= owm_pkg::PresWaitDefault;
      recovery_q  <= owm_pkg::RecoveryDefault;
      slot_q      <= owm_pkg::SlotDefault;
      sample_q    <= owm_pkg::SampleDefault;
      pullup_q    <= owm_pkg::PullupDefault;
    end else if (cfg_we_i) begin
      // Mask each write to its register's width; unknown indexes drop.
      case (cfg_idx_i)
        owm_pkg::CFG_RESET_LOW: reset_low_q <= cfg_data_i[11:0];
        owm_pkg::CFG_PRES_WAIT: pres_wait_q <= cfg_data_i[11:0];
        owm_pkg::CFG_RECOVERY:  recovery_q  <= cfg_data_i[11:0];
        owm_pkg::CFG_SLOT:      slot_q      <= cfg_data_i[7:0];
        owm_pkg::CFG_SAMPLE:    sample_q    <= cfg_data_i[7:0];
        owm_pkg::CFG_PULLUP:    pullup_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: take a word whenever the output register is free or draining.
  // ---------------------------------------------------------------------------
  logic res_valid_q;
  logic cmd_fire;

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  owm_pkg::owm_phase_e phase_q, phase_d;
  timer_t              timer_q, timer_d;
  logic [2:0]          bit_q, bit_d;
  logic [7:0]          shift_q, shift_d;
  logic                pres_q, pres_d;
  logic [7:0]          rd_byte_q, rd_byte_d;
  owm_pkg::owm_res_t   res_q, res_d;

  always_comb begin
    owm_pkg::owm_phase_e ph;
    timer_t              tm;
    logic                drive, pull, done, rej;
    logic                poll_end;

    ph        = phase_q;
    tm        = timer_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    pres_d    = pres_q;
    rd_byte_d = rd_byte_q;
    drive     = 1'b0;
    pull      = 1'b0;
    done      = 1'b0;
    rej       = 1'b0;
    poll_end  = 1'b0;

    // Command decode: a command starts only from idle, and its word is
    // also the first tick of the sequence. Unknown opcodes act as ticks.
    if ((cmd_i.opcode >= owm_pkg::OP_RESET) && (cmd_i.opcode <= owm_pkg::OP_PULLUP)) begin
      if (phase_q != owm_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        unique case (cmd_i.opcode)
          owm_pkg::OP_RESET: begin
            ph = owm_pkg::PH_RST_LOW;
            tm = timer_load(20'(reset_low_q), 1'b1);
          end
          owm_pkg::OP_WRITE: begin
            shift_d = cmd_i.data_byte;
            bit_d   = 3'd0;
            ph      = owm_pkg::PH_WR_LOW;
            tm      = cmd_i.data_byte[0] ? timer_t'(1) : timer_load(20'(slot_q), 1'b1);
          end
          owm_pkg::OP_READ: begin
            bit_d = 3'd0;
            ph    = owm_pkg::PH_RD_LOW;
          end
          default: begin
            ph = owm_pkg::PH_PULLUP;
            tm = timer_load(pullup_q, 1'b1);
          end
        endcase
      end
    end

    // Phase step for this tick.
    unique case (ph)
      owm_pkg::PH_RST_LOW: begin
        drive = 1'b1;
        if (tm <= timer_t'(1)) begin
          ph = owm_pkg::PH_RST_POLL;
          tm = timer_load(20'(pres_wait_q), 1'b1);
        end else begin
          tm = tm - timer_t'(1);
        end
      end
      owm_pkg::PH_RST_POLL: begin
        // A low sample means a slave answered; stop polling at once.
        if (!cmd_i.line_sample) begin
          pres_d   = 1'b1;
          poll_end = 1'b1;
        end else if (tm <= timer_t'(1)) begin
          pres_d   = 1'b0;
          poll_end = 1'b1;
        end else begin
          tm = tm - timer_t'(1);
        end
        if (poll_end) begin
          if (recovery_q == 12'd0) begin
            ph   = owm_pkg::PH_IDLE;
            done = 1'b1;
          end else begin
            ph = owm_pkg::PH_RST_REC;
            tm = timer_load(20'(recovery_q), 1'b1);
          end
        end
      end
      owm_pkg::PH_RST_REC: begin
        if (tm <= timer_t'(1)) begin
          ph   = owm_pkg::PH_IDLE;
          done = 1'b1;
        end else begin
          tm = tm - timer_t'(1);
        end
      end
      owm_pkg::PH_WR_LOW: begin
        drive = 1'b1;
        if (tm <= timer_t'(1)) begin
          ph = owm_pkg::PH_WR_HIGH;
          tm = shift_d[0] ? timer_load(20'(slot_q), 1'b1) : timer_t'(1);
        end else begin
          tm = tm - timer_t'(1);
        end
      end
      owm_pkg::PH_WR_HIGH: begin
        if (tm <= timer_t'(1)) begin
          // Advance to the next bit, LSB first.
          shift_d = {1'b0, shift_d[7:1]};
          if (bit_d == 3'd7) begin
            ph   = owm_pkg::PH_IDLE;
            done = 1'b1;
          end else begin
            bit_d = bit_d + 3'd1;
            ph    = owm_pkg::PH_WR_LOW;
            tm    = shift_d[0] ? timer_t'(1) : timer_load(20'(slot_q), 1'b1);
          end
        end else begin
          tm = tm - timer_t'(1);
        end
      end
      owm_pkg::PH_RD_LOW: begin
        drive = 1'b1;
        ph    = owm_pkg::PH_RD_WAIT;
        tm    = timer_load(20'(sample_q), 1'b0);
      end
      owm_pkg::PH_RD_WAIT: begin
        if (tm == '0) begin
          // Sample the line into the top bit; the byte fills LSB first.
          shift_d = {cmd_i.line_sample, shift_d[7:1]};
          ph      = owm_pkg::PH_RD_REST;
          tm      = timer_load(20'(slot_q), 1'b1);
        end else begin
          tm = tm - timer_t'(1);
        end
      end
      owm_pkg::PH_RD_REST: begin
        if (tm <= timer_t'(1)) begin
          if (bit_d == 3'd7) begin
            rd_byte_d = shift_d;
            ph        = owm_pkg::PH_IDLE;
            done      = 1'b1;
          end else begin
            bit_d = bit_d + 3'd1;
            ph    = owm_pkg::PH_RD_LOW;
          end
        end else begin
          tm = tm - timer_t'(1);
        end
      end
      owm_pkg::PH_PULLUP: begin
        pull = 1'b1;
        if (tm <= timer_t'(1)) begin
          ph   = owm_pkg::PH_IDLE;
          done = 1'b1;
        end else begin
          tm = tm - timer_t'(1);
        end
      end
      default: begin
        ph = owm_pkg::PH_IDLE;
      end
    endcase

    phase_d          = ph;
    timer_d          = tm;
    res_d.drive_low  = drive;
    res_d.pullup_on  = pull;
    res_d.busy_res   = (ph != owm_pkg::PH_IDLE);
    res_d.done_res   = done;
    res_d.presence   = pres_d;
    res_d.read_value = rd_byte_d;
    res_d.rejected   = rej;
  end

  // Commit the step only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= owm_pkg::PH_IDLE;
      timer_q   <= '0;
      bit_q     <= 3'd0;
      shift_q   <= 8'd0;
      pres_q    <= 1'b0;
      rd_byte_q <= 8'd0;
    end else if (cmd_fire) begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      pres_q    <= pres_d;
      rd_byte_q <= rd_byte_d;
    end
  end

  // Output register: load on accept, drop the word once it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.drive_low  = res_q.drive_low;
  assign res_o.pullup_on  = res_q.pullup_on;
  assign res_o.busy_res   = res_q.busy_res;
  assign res_o.done_res   = res_q.done_res;
  assign res_o.presence   = res_q.presence;
  assign res_o.read_value = res_q.read_value;
  assign res_o.rejected   = res_q.rejected;

endmodule

FILE: src/owm_checker.sv
// Port-level checks for the 1-Wire bus master, bound to the top level.
`timescale 1ns / 1ps

module owm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cmd_valid_i,
  input logic       cmd_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       drive_low_i,
  input logic       pullup_on_i,
  input logic       busy_res_i,
  input logic       done_res_i,
  input logic       presence_i,
  input logic [7:0] read_value_i,
  input logic       rejected_i
);

  // Hold a stalled result word.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(read_value_i) && $stable(done_res_i)
      && $stable(presence_i) && $stable(rejected_i))
    else $error("stalled result word changed");

  // Every accepted tick word yields a result word in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> res_valid_i)
    else $error("accepted word produced no result");

  // Never pull low and drive hard high on the same tick.
  a_no_contention: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(drive_low_i && pullup_on_i))
    else $error("line driven low and strongly high together");

  // A finished sequence leaves the master idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && done_res_i |-> !busy_res_i)
    else $error("done reported while still busy");

endmodule

bind onewire_master_controller owm_checker u_owm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .drive_low_i  (res_o.drive_low),
  .pullup_on_i  (res_o.pullup_on),
  .busy_res_i   (res_o.busy_res),
  .done_res_i   (res_o.done_res),
  .presence_i   (res_o.presence),
  .read_value_i (res_o.read_value),
  .rejected_i   (res_o.rejected)
);
